FILE: rtl/path_forest_cycle_oracle_top_assert.svh
// ----------------------------------------------------------------------------
// Path forest cycle oracle: assertion macros
// Concurrent assertion helpers, switched out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PATH_FOREST_CYCLE_ORACLE_TOP_ASSERT_SVH
`define PATH_FOREST_CYCLE_ORACLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, masked during reset
`define PFCO_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define PFCO_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFCO_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define PFCO_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

FILE: rtl/pfco_pkg.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: package
// Field widths, codes and the structs passed between the control and stores.
// ----------------------------------------------------------------------------
package pfco_pkg;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 10;
  localparam int VERTEX_W = 8;
  localparam int ERR_W    = 2;
  localparam int VCOUNT_W = 9;
  localparam int STEP_W   = 10;

  // address spaces the item fields can reach
  localparam int VERTEX_SPACE = 1 << VERTEX_W;
  localparam int EDGE_SPACE   = 1 << IDX_W;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 1024;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_WALK      = 2'd1,
    ERR_NOT_FOUND = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] tail;
    logic [VERTEX_W-1:0] head;
  } edge_word_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
    edge_word_t       wdata;
  } edge_req_t;

  typedef struct packed {
    logic                rd_en;
    logic [VERTEX_W-1:0] rd_addr;
    logic                wr_en;
    logic [VERTEX_W-1:0] wr_addr;
    logic                wr_valid;
    logic [VERTEX_W-1:0] wr_vertex;
  } succ_req_t;

  typedef struct packed {
    logic                valid;
    logic [VERTEX_W-1:0] vertex;
  } succ_rd_t;

endpackage

FILE: rtl/pfco_in_if.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: input channel
// Valid/ready channel carrying one edge command per beat.
// ----------------------------------------------------------------------------
interface pfco_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfco_pkg::KIND_W-1:0]   kind;
  logic [pfco_pkg::IDX_W-1:0]    edge_index;
  logic [pfco_pkg::VERTEX_W-1:0] edge_tail;
  logic [pfco_pkg::VERTEX_W-1:0] edge_head;

  modport source (output valid, output kind, output edge_index, output edge_tail,
                  output edge_head, input ready);
  modport sink (input valid, input kind, input edge_index, input edge_tail,
                input edge_head, output ready);
endinterface

FILE: rtl/pfco_out_if.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: result channel
// Valid/ready channel carrying one verdict per beat.
// ----------------------------------------------------------------------------
interface pfco_out_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [pfco_pkg::ERR_W-1:0] error_code;

  modport source (output valid, output accepted, output error_code, input ready);
  modport sink (input valid, input accepted, input error_code, output ready);
endinterface

FILE: rtl/pfco_edge_mem.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: edge store
// Single-port synchronous memory of edge tail/head pairs, registered read.
// ----------------------------------------------------------------------------
module pfco_edge_mem #(
  parameter int MAX_EDGES = pfco_pkg::DEF_MAX_EDGES
) (
  input  logic                 clk,
  input  pfco_pkg::edge_req_t  req,
  output pfco_pkg::edge_word_t rdata
);
  import pfco_pkg::*;

  localparam int EDGE_DEPTH = (MAX_EDGES < EDGE_SPACE) ? MAX_EDGES : EDGE_SPACE;
  localparam int EAW        = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;

  edge_word_t mem [EDGE_DEPTH];
  edge_word_t rdata_r;

  // write on load, read on add or remove; control never issues both at once
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.idx[EAW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.idx[EAW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pfco_succ_mem.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: successor store
// Per-vertex successor memory with a flop valid bit per entry, registered read.
// ----------------------------------------------------------------------------
module pfco_succ_mem #(
  parameter int MAX_VERTICES = pfco_pkg::DEF_MAX_VERTICES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfco_pkg::succ_req_t req,
  output pfco_pkg::succ_rd_t  rd
);
  import pfco_pkg::*;

  localparam int SUCC_DEPTH = (MAX_VERTICES < VERTEX_SPACE) ? MAX_VERTICES : VERTEX_SPACE;
  localparam int SAW        = $clog2(SUCC_DEPTH);

  logic [VERTEX_W-1:0]   mem [SUCC_DEPTH];
  logic [SUCC_DEPTH-1:0] valid_r;
  logic                  rd_valid_r;
  logic [VERTEX_W-1:0]   rd_vertex_r;
  logic                  rd_in_range;
  logic                  wr_in_range;

  // vertices beyond the store read as empty and drop writes
  assign rd_in_range = (32'(req.rd_addr) < 32'(SUCC_DEPTH));
  assign wr_in_range = (32'(req.wr_addr) < 32'(SUCC_DEPTH));

  // pointer payload: no reset, emptiness lives in the valid bits
  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem[req.wr_addr[SAW-1:0]] <= req.wr_vertex;
    end
    if (req.rd_en) begin
      rd_vertex_r <= mem[req.rd_addr[SAW-1:0]];
    end
  end

  // valid bits: cleared together at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en && wr_in_range) begin
        valid_r[req.wr_addr[SAW-1:0]] <= req.wr_valid;
      end
      if (req.rd_en) begin
        rd_valid_r <= rd_in_range && valid_r[req.rd_addr[SAW-1:0]];
      end
    end
  end

  assign rd.valid  = rd_valid_r;
  assign rd.vertex = rd_vertex_r;

endmodule

FILE: rtl/pfco_ctrl.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: control
// Command sequencer: edge lookup, successor walk, verdict and output register.
// ----------------------------------------------------------------------------
`include "path_forest_cycle_oracle_top_assert.svh"

module pfco_ctrl #(
  parameter int MAX_EDGES = pfco_pkg::DEF_MAX_EDGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfco_in_if.sink                        in_ch,
  pfco_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [pfco_pkg::VCOUNT_W-1:0]  cfg_wr_data,
  output pfco_pkg::edge_req_t            edge_req,
  input  pfco_pkg::edge_word_t           edge_rdata,
  output pfco_pkg::succ_req_t            succ_req,
  input  pfco_pkg::succ_rd_t             succ_rd
);
  import pfco_pkg::*;

  localparam int EDGE_DEPTH = (MAX_EDGES < EDGE_SPACE) ? MAX_EDGES : EDGE_SPACE;

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [VERTEX_W-1:0] tail_r, tail_nxt;
  logic [VERTEX_W-1:0] head_r, head_nxt;
  logic [VERTEX_W-1:0] cur_r, cur_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic                res_acc_r, res_acc_nxt;
  err_t                res_err_r, res_err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  err_t                out_err_r, out_err_nxt;
  logic [VCOUNT_W-1:0] vcount_r;

  logic                in_fire;
  logic                idx_ok;
  logic                is_lookup;
  logic                out_free;
  logic [STEP_W-1:0]   step_inc;
  logic                over_bound;
  logic [VERTEX_W-1:0] start_vertex;

  // handshake and shared decisions
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign idx_ok       = (32'(in_ch.edge_index) < 32'(EDGE_DEPTH));
  assign is_lookup    = (in_ch.kind == KIND_ADD) || (in_ch.kind == KIND_REMOVE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign step_inc     = steps_r + STEP_W'(1);
  assign over_bound   = (step_inc > STEP_W'(vcount_r));
  assign start_vertex = (kind_r == KIND_REMOVE) ? edge_rdata.tail : edge_rdata.head;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (idx_ok && is_lookup) ? ST_EDGE : ST_RESP;
        end
      end
      ST_EDGE: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (kind_r == KIND_REMOVE) begin
          state_nxt = ST_RESP;
        end else if (succ_rd.valid && !over_bound) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // store requests, walk datapath and verdict
  always_comb begin
    edge_req      = '0;
    succ_req      = '0;
    kind_nxt      = kind_r;
    tail_nxt      = tail_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    res_acc_nxt   = res_acc_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_err_nxt   = out_err_r;

    edge_req.idx        = in_ch.edge_index;
    edge_req.wdata.tail = in_ch.edge_tail;
    edge_req.wdata.head = in_ch.edge_head;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt    = in_ch.kind;
          res_acc_nxt = 1'b0;
          res_err_nxt = ERR_NONE;
          if (idx_ok && (in_ch.kind == KIND_LOAD)) begin
            edge_req.wr_en = 1'b1;
            res_acc_nxt    = 1'b1;
          end
          if (idx_ok && is_lookup) begin
            edge_req.rd_en = 1'b1;
          end
        end
      end
      ST_EDGE: begin
        // latch the edge and fetch the first successor
        tail_nxt         = edge_rdata.tail;
        head_nxt         = edge_rdata.head;
        cur_nxt          = start_vertex;
        steps_nxt        = '0;
        succ_req.rd_en   = 1'b1;
        succ_req.rd_addr = start_vertex;
      end
      ST_WALK: begin
        if (kind_r == KIND_REMOVE) begin
          if (succ_rd.valid && (succ_rd.vertex == head_r)) begin
            succ_req.wr_en    = 1'b1;
            succ_req.wr_addr  = tail_r;
            succ_req.wr_valid = 1'b0;
            res_acc_nxt       = 1'b1;
            res_err_nxt       = ERR_NONE;
          end else begin
            res_acc_nxt = 1'b0;
            res_err_nxt = ERR_NOT_FOUND;
          end
        end else if (succ_rd.valid) begin
          // one step along the path
          steps_nxt = step_inc;
          if (over_bound) begin
            res_acc_nxt = 1'b0;
            res_err_nxt = ERR_WALK;
          end else begin
            cur_nxt          = succ_rd.vertex;
            succ_req.rd_en   = 1'b1;
            succ_req.rd_addr = succ_rd.vertex;
          end
        end else if (cur_r == tail_r) begin
          // path ends at the tail: the edge would close a cycle
          res_acc_nxt = 1'b0;
          res_err_nxt = ERR_NONE;
        end else begin
          succ_req.wr_en     = 1'b1;
          succ_req.wr_addr   = tail_r;
          succ_req.wr_valid  = 1'b1;
          succ_req.wr_vertex = head_r;
          res_acc_nxt        = 1'b1;
          res_err_nxt        = ERR_NONE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_err_nxt   = res_err_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vcount_r    <= VCOUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    tail_r    <= tail_nxt;
    head_r    <= head_nxt;
    cur_r     <= cur_nxt;
    steps_r   <= steps_nxt;
    res_acc_r <= res_acc_nxt;
    res_err_r <= res_err_nxt;
    out_acc_r <= out_acc_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.error_code = out_err_r;

  `PFCO_ASSERT_IMP(a_walk_bound, clk, rst_n, state_r == ST_WALK, steps_r <= STEP_W'(vcount_r), "walk step count past vertex bound")
  `PFCO_ASSERT_NXT(a_accept_busy, clk, rst_n, in_fire, state_r != ST_IDLE, "accepted beat left the sequencer idle")
  `PFCO_ASSERT_IMP(a_succ_write, clk, rst_n, succ_req.wr_en, (state_r == ST_WALK) && !succ_req.rd_en, "successor written outside the walk end")
  `PFCO_ASSERT_NXT(a_resp_load, clk, rst_n, (state_r == ST_RESP) && out_free, out_valid_r && (out_acc_r == $past(res_acc_r)), "verdict not moved to the output register")

endmodule

FILE: rtl/path_forest_cycle_oracle_top.sv
// ----------------------------------------------------------------------------
// Path forest cycle oracle: top level
// Edge table plus per-vertex successor pointers; answers whether an edge
// would close a cycle, and adds or removes it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per beat (load edge, try add, remove); out_ch
//   returns one verdict beat per command: accepted and error_code.
//   cfg_wr_en/cfg_wr_data set vertex_count; write it only while idle.
// Timing:
//   One item at a time. A load, an ignored command or an index out of range
//   reaches the verdict register straight from its accept; a remove passes
//   ST_EDGE and ST_WALK first. Try add passes ST_EDGE, then ST_WALK for each
//   of k successor hops (at most vertex_count) and once more where the path
//   ends; a walk that overruns stops at hop vertex_count + 1. One successor
//   read per cycle, each address from the last data. The next command is
//   accepted in the cycle after the verdict is moved to the output register.
// Reset:
//   rst_n (synchronous) empties every successor at once via per-vertex valid
//   flops, sets vertex_count to 256; the edge table is not cleared.
// Stall:
//   A verdict waits in the output register while out_ch.ready is low; the
//   sequencer may finish the next item and then holds it until the slot frees.
// ----------------------------------------------------------------------------
module path_forest_cycle_oracle_top #(
  parameter int MAX_VERTICES = pfco_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = pfco_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pfco_in_if.sink                       in_ch,
  pfco_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [pfco_pkg::VCOUNT_W-1:0] cfg_wr_data
);
  import pfco_pkg::*;

  edge_req_t  edge_req;
  edge_word_t edge_rdata;
  succ_req_t  succ_req;
  succ_rd_t   succ_rd;

  // sequencer
  pfco_ctrl #(
    .MAX_EDGES (MAX_EDGES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .edge_req    (edge_req),
    .edge_rdata  (edge_rdata),
    .succ_req    (succ_req),
    .succ_rd     (succ_rd)
  );

  // edge table
  pfco_edge_mem #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_mem (
    .clk   (clk),
    .req   (edge_req),
    .rdata (edge_rdata)
  );

  // successor pointers
  pfco_succ_mem #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_succ_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (succ_req),
    .rd    (succ_rd)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path forest cycle oracle: self-checking testbench
// Drives load, try-add and remove commands through the input channel, keeps
// its own copy of the edge table, successor pointers and vertex count, and
// checks every verdict beat against that copy. A short table of directed
// commands comes first, then random traffic in phases of vertex count and
// channel idling.
// ----------------------------------------------------------------------------
module testbench;
  import pfco_pkg::*;

  // kind code that the block leaves unused
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  // cycles with no beat on either channel before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  // quiet cycles before a register write and after the last verdict
  localparam int CFG_SETTLE  = 4;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    idx;
    logic [VERTEX_W-1:0] tail;
    logic [VERTEX_W-1:0] head;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    err_t err;
  } verdict_t;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           rk;
    logic [VCOUNT_W-1:0] cfg_val;
    cmd_t                cmd;
    bit                  typed;
    verdict_t            want;
  } plan_row_t;

  localparam int PLAN_LEN = 23;

  // directed commands; a typed verdict is used where it is plain to see
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd0, 8'd0, 8'd1}, 1'b1, '{1'b1, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd1023, 8'd255, 8'd255}, 1'b1, '{1'b1, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd1, 8'd1, 8'd0}, 1'b1, '{1'b1, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd2, 8'd1, 8'd2}, 1'b1, '{1'b1, ERR_NONE}},
    // nothing added yet: remove must miss
    '{ROW_CMD, 9'd0, '{KIND_REMOVE, 10'd0, 8'd0, 8'd0}, 1'b1, '{1'b0, ERR_NOT_FOUND}},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd0, 8'd0, 8'd0}, 1'b0, '0},
    // back edge closes a cycle, self loop too
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd1, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd1023, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd2, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd3, 8'd2, 8'd3}, 1'b1, '{1'b1, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd3, 8'd0, 8'd0}, 1'b0, '0},
    // shortest walk bound: a path of three hops is too long
    '{ROW_CFG, 9'd1, '0, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd4, 8'd9, 8'd0}, 1'b1, '{1'b1, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd4, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CFG, 9'd256, '0, 1'b0, '0},
    // overwrite a live successor, then build a loop and walk into it
    '{ROW_CMD, 9'd0, '{KIND_LOAD, 10'd5, 8'd1, 8'd3}, 1'b1, '{1'b1, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd5, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd1, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_ADD, 10'd4, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_REMOVE, 10'd1, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{KIND_REMOVE, 10'd1, 8'd0, 8'd0}, 1'b0, '0},
    // unused kind does nothing
    '{ROW_CMD, 9'd0, '{KIND_NOP, 10'd1023, 8'd255, 8'd255}, 1'b1, '{1'b0, ERR_NONE}},
    '{ROW_CMD, 9'd0, '{KIND_NOP, 10'd0, 8'd0, 8'd0}, 1'b1, '{1'b0, ERR_NONE}}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [VCOUNT_W-1:0] cfg_wr_data;

  pfco_in_if  in_ch ();
  pfco_out_if out_ch ();

  path_forest_cycle_oracle_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow of the block's state
  logic                succ_live     [VERTEX_SPACE];
  logic [VERTEX_W-1:0] succ_to       [VERTEX_SPACE];
  logic [VERTEX_W-1:0] edge_tail_mem [EDGE_SPACE];
  logic [VERTEX_W-1:0] edge_head_mem [EDGE_SPACE];
  logic [VCOUNT_W-1:0] vcount_model;

  // entries loaded so far; add and remove only name these
  bit          loaded_map [EDGE_SPACE];
  int unsigned loaded_list[$];

  verdict_t verdict_q[$];
  int       fault_count;
  int       quiet_cycles;
  int       send_idle_pct;
  int       recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // work out the verdict of one command and advance the shadow state
  function automatic verdict_t judge_cmd(cmd_t c);
    verdict_t            r;
    logic [VERTEX_W-1:0] t;
    logic [VERTEX_W-1:0] h;
    logic [VERTEX_W-1:0] v;
    int unsigned         hops;
    r.accepted = 1'b0;
    r.err      = ERR_NONE;
    t          = edge_tail_mem[c.idx];
    h          = edge_head_mem[c.idx];
    if (c.kind == KIND_LOAD) begin
      edge_tail_mem[c.idx] = c.tail;
      edge_head_mem[c.idx] = c.head;
      r.accepted = 1'b1;
    end else if (c.kind == KIND_REMOVE) begin
      if (succ_live[t] && succ_to[t] == h) begin
        succ_live[t] = 1'b0;
        succ_to[t]   = '0;
        r.accepted   = 1'b1;
      end else begin
        r.err = ERR_NOT_FOUND;
      end
    end else if (c.kind == KIND_ADD) begin
      // follow the path from the head; stop once it outruns the vertex count
      v    = h;
      hops = 0;
      while (succ_live[v] && r.err == ERR_NONE) begin
        v    = succ_to[v];
        hops = hops + 1;
        if (hops > vcount_model) r.err = ERR_WALK;
      end
      if (r.err == ERR_NONE && v != t) begin
        succ_live[t] = 1'b1;
        succ_to[t]   = h;
        r.accepted   = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [VERTEX_W-1:0] pick_vertex();
    // mostly a dense cluster so that paths grow long and loops form
    if ($urandom_range(99) < 85) return VERTEX_W'($urandom_range(11));
    return VERTEX_W'($urandom_range(VERTEX_SPACE - 1));
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99) < 80) return IDX_W'($urandom_range(47));
    return IDX_W'($urandom_range(EDGE_SPACE - 1));
  endfunction

  function automatic logic [IDX_W-1:0] pick_loaded();
    return IDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  task automatic flag(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fault_count++;
  endtask

  // present one command, hold it until the beat is taken, then predict it
  task automatic issue(cmd_t c, bit typed, verdict_t want);
    verdict_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= c.kind;
    in_ch.edge_index <= c.idx;
    in_ch.edge_tail  <= c.tail;
    in_ch.edge_head  <= c.head;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = judge_cmd(c);
    verdict_q.insert(verdict_q.size(), typed ? want : got);
    if (c.kind == KIND_LOAD && !loaded_map[c.idx]) begin
      loaded_map[c.idx] = 1'b1;
      loaded_list.insert(loaded_list.size(), 32'(c.idx));
    end
  endtask

  // drain the block, then set the vertex count
  task automatic write_vcount(logic [VCOUNT_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    vcount_model = v;
  endtask

  // random traffic: mostly load-then-add pairs and adds or removes of known
  // entries, with a little noise of the unused kind
  task automatic play_random(int n);
    cmd_t        c;
    int          done;
    int          roll;
    int          tries;
    logic [IDX_W-1:0] pick;
    done = 0;
    while (done < n) begin
      roll   = $urandom_range(99);
      c.tail = VERTEX_W'($urandom_range(VERTEX_SPACE - 1));
      c.head = VERTEX_W'($urandom_range(VERTEX_SPACE - 1));
      if (roll < 30 || loaded_list.size() == 0) begin
        c.kind = KIND_LOAD;
        c.idx  = pick_index();
        c.tail = pick_vertex();
        c.head = pick_vertex();
        issue(c, 1'b0, '0);
        c.kind = KIND_ADD;
        issue(c, 1'b0, '0);
        done += 2;
      end else if (roll < 60) begin
        c.kind = KIND_ADD;
        c.idx  = pick_loaded();
        issue(c, 1'b0, '0);
        done++;
      end else if (roll < 82) begin
        // prefer an entry whose edge is live so that removes hit
        c.kind = KIND_REMOVE;
        tries  = 0;
        do begin
          pick  = pick_loaded();
          tries = tries + 1;
        end while (tries < 8 && !(succ_live[edge_tail_mem[pick]] &&
                                  succ_to[edge_tail_mem[pick]] == edge_head_mem[pick]));
        c.idx = pick;
        issue(c, 1'b0, '0);
        done++;
      end else if (roll < 95) begin
        c.kind = KIND_LOAD;
        c.idx  = pick_index();
        c.tail = pick_vertex();
        c.head = pick_vertex();
        issue(c, 1'b0, '0);
        done++;
      end else begin
        c.kind = KIND_NOP;
        c.idx  = IDX_W'($urandom_range(EDGE_SPACE - 1));
        issue(c, 1'b0, '0);
        done++;
      end
    end
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check verdict beats in order and count cycles without progress
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        flag("verdict beat with no command pending");
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_ch.accepted !== exp_v.accepted)
          flag($sformatf("accepted %b, want %b", out_ch.accepted, exp_v.accepted));
        if (out_ch.error_code !== exp_v.err)
          flag($sformatf("error_code %0d, want %0d", out_ch.error_code, exp_v.err));
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = '0;
    in_ch.edge_index = '0;
    in_ch.edge_tail  = '0;
    in_ch.edge_head  = '0;
    fault_count      = 0;
    send_idle_pct    = 35;
    recv_idle_pct    = 63;
    vcount_model     = VCOUNT_RESET;
    foreach (succ_live[i]) begin
      succ_live[i] = 1'b0;
      succ_to[i]   = '0;
    end
    foreach (loaded_map[i]) loaded_map[i] = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[k]) begin
      if (plan[k].rk == ROW_CFG) write_vcount(plan[k].cfg_val);
      else issue(plan[k].cmd, plan[k].typed, plan[k].want);
    end

    // random phases: sender idles less than receiver, then the reverse,
    // then no idling at all
    write_vcount(9'd256);
    play_random(90);
    write_vcount(9'd3);
    play_random(90);
    send_idle_pct = 63;
    recv_idle_pct = 35;
    write_vcount(9'd1);
    play_random(90);
    write_vcount(9'd40);
    play_random(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_vcount(VCOUNT_W'($urandom_range(2, 255)));
    play_random(90);
    write_vcount(9'd256);
    play_random(100);

    // drain, then allow a full walk for any stray beat
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
